>>> rtl/core/dafb_pkg.sv
// Shared types and constants for the dual-axis flow biquad block.
// Used by every module under rtl/core; depends on nothing.
package dafb_pkg;

  localparam int COEF_W    = 16;
  localparam int SAMPLE_W  = 8;
  localparam int FINE_W    = 24;
  localparam int SUM_W     = 32;
  localparam int QUAL_W    = 8;
  localparam int RATE_W    = 9;
  // three 16x8 feedforward products, each within +/-2^22
  localparam int FF_W      = 26;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [FINE_W-1:0]   fine_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [QUAL_W-1:0]   qual_t;
  typedef logic signed [RATE_W-1:0]   rate_t;
  typedef logic signed [FF_W-1:0]     ff_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2
  } cfg_reg_t;

  localparam coef_t B0_RESET = 16'sh4000;
  localparam fine_t FINE_MAX = 24'sh7FFFFF;
  localparam fine_t FINE_MIN = 24'sh800000;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coefs_t;

  typedef struct packed {
    ff_t   ff_x;
    ff_t   ff_y;
    sum_t  sum_x;
    sum_t  sum_y;
    qual_t quality;
  } ff_item_t;

  typedef struct packed {
    fine_t filt_x;
    fine_t filt_y;
    sum_t  sum_x;
    sum_t  sum_y;
    qual_t quality;
  } fb_item_t;

  typedef struct packed {
    fine_t   flow_x_fine;
    fine_t   flow_y_fine;
    sample_t flow_x;
    sample_t flow_y;
    rate_t   rate_x;
    rate_t   rate_y;
    sum_t    sum_x;
    sum_t    sum_y;
    qual_t   quality_out;
  } out_item_t;

endpackage

>>> rtl/core/dafb_ff.sv
// Feedforward stage: input history, b0/b1/b2 products and raw running sums.
// Depends on dafb_pkg.
module dafb_ff (
  input  logic              clk,
  input  logic              rst,
  input  dafb_pkg::coefs_t  coefs,
  input  logic              in_valid,
  output logic              in_ready,
  input  dafb_pkg::sample_t dx,
  input  dafb_pkg::sample_t dy,
  input  dafb_pkg::qual_t   quality,
  output logic              out_valid,
  input  logic              out_ready,
  output dafb_pkg::ff_item_t out_item
);
  import dafb_pkg::*;

  localparam int FF_PROD_W = COEF_W + SAMPLE_W;

  logic    fire;
  sample_t xh1_x, xh2_x, xh1_y, xh2_y;
  sum_t    sum_x, sum_y;
  sum_t    sum_x_next, sum_y_next;
  ff_t     ff_x_next, ff_y_next;

  function automatic ff_t ff_sum(coef_t b0, coef_t b1, coef_t b2,
                                 sample_t x0, sample_t x1, sample_t x2);
    logic signed [FF_PROD_W-1:0] p0, p1, p2;
    p0 = FF_PROD_W'(b0) * FF_PROD_W'(x0);
    p1 = FF_PROD_W'(b1) * FF_PROD_W'(x1);
    p2 = FF_PROD_W'(b2) * FF_PROD_W'(x2);
    return FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    ff_x_next  = ff_sum(coefs.b0, coefs.b1, coefs.b2, dx, xh1_x, xh2_x);
    ff_y_next  = ff_sum(coefs.b0, coefs.b1, coefs.b2, dy, xh1_y, xh2_y);
    sum_x_next = sum_x + SUM_W'(dx);
    sum_y_next = sum_y + SUM_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      xh1_x     <= '0;
      xh2_x     <= '0;
      xh1_y     <= '0;
      xh2_y     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        xh2_x <= xh1_x;
        xh1_x <= dx;
        xh2_y <= xh1_y;
        xh1_y <= dy;
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.ff_x    <= ff_x_next;
      out_item.ff_y    <= ff_y_next;
      out_item.sum_x   <= sum_x_next;
      out_item.sum_y   <= sum_y_next;
      out_item.quality <= quality;
    end
  end

endmodule

>>> rtl/core/dafb_fb.sv
// Feedback stage: a1/a2 terms, rounding, 24-bit saturation, output history.
// Depends on dafb_pkg.
module dafb_fb #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int OUT_FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  dafb_pkg::coefs_t   coefs,
  input  logic               in_valid,
  output logic               in_ready,
  input  dafb_pkg::ff_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dafb_pkg::fb_item_t out_item
);
  import dafb_pkg::*;

  localparam int FF_SH_W = FF_W + OUT_FRAC_BITS;
  localparam int PROD_W  = COEF_W + FINE_W;
  localparam int ACC_W   = ((FF_SH_W > PROD_W) ? FF_SH_W : PROD_W) + 3;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(2 ** (COEF_FRAC_BITS - 1));

  logic  fire;
  fine_t yh1_x, yh2_x, yh1_y, yh2_y;
  fine_t y_x_next, y_y_next;

  function automatic fine_t iir_fb(ff_t ff, coef_t a1, coef_t a2, fine_t y1, fine_t y2);
    logic signed [PROD_W-1:0] p1, p2;
    logic signed [ACC_W-1:0]  acc, shr;
    fine_t                    res;
    p1  = PROD_W'(a1) * PROD_W'(y1);
    p2  = PROD_W'(a2) * PROD_W'(y2);
    acc = (ACC_W'(ff) <<< OUT_FRAC_BITS) - ACC_W'(p1) - ACC_W'(p2) + ROUND;
    shr = acc >>> COEF_FRAC_BITS;
    // upper bits must all match the sign to fit in 24 bits
    if (!shr[ACC_W-1] && (|shr[ACC_W-2:FINE_W-1])) begin
      res = FINE_MAX;
    end else if (shr[ACC_W-1] && !(&shr[ACC_W-2:FINE_W-1])) begin
      res = FINE_MIN;
    end else begin
      res = shr[FINE_W-1:0];
    end
    return res;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    y_x_next = iir_fb(in_item.ff_x, coefs.a1, coefs.a2, yh1_x, yh2_x);
    y_y_next = iir_fb(in_item.ff_y, coefs.a1, coefs.a2, yh1_y, yh2_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      yh1_x     <= '0;
      yh2_x     <= '0;
      yh1_y     <= '0;
      yh2_y     <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        yh2_x <= yh1_x;
        yh1_x <= y_x_next;
        yh2_y <= yh1_y;
        yh1_y <= y_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.filt_x  <= y_x_next;
      out_item.filt_y  <= y_y_next;
      out_item.sum_x   <= in_item.sum_x;
      out_item.sum_y   <= in_item.sum_y;
      out_item.quality <= in_item.quality;
    end
  end

`ifndef NO_ASSERTIONS
  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    fire |=> (yh2_x == $past(yh1_x)) && (yh2_y == $past(yh1_y)))
    else $error("output history did not shift on accepted item");

  a_hist_matches_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> (yh1_x == out_item.filt_x) && (yh1_y == out_item.filt_y))
    else $error("stored history differs from forwarded filter value");

  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(yh1_x) && $stable(yh1_y) && $stable(yh2_x) && $stable(yh2_y))
    else $error("output history changed without an accepted item");
`endif

endmodule

>>> rtl/core/dafb_out.sv
// Output stage: axis swap with saturating negation, int8 conversion, rates,
// and the result register. Depends on dafb_pkg.
module dafb_out #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dafb_pkg::fb_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dafb_pkg::out_item_t out_item
);
  import dafb_pkg::*;

  logic    fire;
  sample_t last_x, last_y;
  fine_t   fine_x_next, fine_y_next;
  sample_t int_x_next, int_y_next;

  function automatic fine_t neg_sat(fine_t v);
    return (v == FINE_MIN) ? FINE_MAX : -v;
  endfunction

  // divide by 2^OUT_FRAC_BITS toward zero, then clamp to int8
  function automatic sample_t to_int8(fine_t v);
    logic [FINE_W-1:0] mag, q;
    sample_t           res;
    mag = v[FINE_W-1] ? FINE_W'(-v) : v;
    q   = mag >> OUT_FRAC_BITS;
    if (v[FINE_W-1]) begin
      res = (q >= FINE_W'(128)) ? sample_t'(-128) : -sample_t'(q[SAMPLE_W-1:0]);
    end else begin
      res = (q > FINE_W'(127)) ? sample_t'(127) : sample_t'(q[SAMPLE_W-1:0]);
    end
    return res;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    fine_x_next = neg_sat(in_item.filt_y);
    fine_y_next = neg_sat(in_item.filt_x);
    int_x_next  = to_int8(fine_x_next);
    int_y_next  = to_int8(fine_y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        last_x <= int_x_next;
        last_y <= int_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.flow_x_fine <= fine_x_next;
      out_item.flow_y_fine <= fine_y_next;
      out_item.flow_x      <= int_x_next;
      out_item.flow_y      <= int_y_next;
      out_item.rate_x      <= RATE_W'(int_x_next) - RATE_W'(last_x);
      out_item.rate_y      <= RATE_W'(int_y_next) - RATE_W'(last_y);
      out_item.sum_x       <= in_item.sum_x;
      out_item.sum_y       <= in_item.sum_y;
      out_item.quality_out <= in_item.quality;
    end
  end

endmodule

>>> rtl/core/dual_axis_flow_biquad.sv
// Dual-axis optical-flow biquad: three register stages, one item per cycle unless stalled.
// Each accepted item is registered in the ff, fb and out stages in turn before
// m_axis_tvalid rises; the a1/a2 multiply-accumulate loop closes within the
// feedback stage, so back-to-back items need no bubble between them.
// Reset (rst, synchronous): clears histories, sums and valids; b0 = 1.0, others 0.
// Depends on dafb_pkg, dafb_ff, dafb_fb, dafb_out.
module dual_axis_flow_biquad #(
  parameter int COEF_FRAC_BITS = 14,
  parameter int OUT_FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dafb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dafb_pkg::COEF_W-1:0]    cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // dx_raw[7:0], dy_raw[15:8], quality[23:16]
  input  logic [23:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // flow_x_fine[23:0], flow_y_fine[47:24], flow_x[55:48], flow_y[63:56],
  // rate_x[72:64], rate_y[81:73], sum_x[113:82], sum_y[145:114],
  // quality_out[153:146], zero[159:154]
  output logic [159:0]                   m_axis_tdata
);
  import dafb_pkg::*;

  coefs_t    coefs;
  logic      ff_valid, ff_ready, fb_valid, fb_ready;
  ff_item_t  ff_item;
  fb_item_t  fb_item;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_B0:  coefs.b0 <= cfg_data;
        REG_B1:  coefs.b1 <= cfg_data;
        REG_B2:  coefs.b2 <= cfg_data;
        REG_A1:  coefs.a1 <= cfg_data;
        REG_A2:  coefs.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  dafb_ff u_ff (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dx        (s_axis_tdata[7:0]),
    .dy        (s_axis_tdata[15:8]),
    .quality   (s_axis_tdata[23:16]),
    .out_valid (ff_valid),
    .out_ready (ff_ready),
    .out_item  (ff_item)
  );

  dafb_fb #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS)
  ) u_fb (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .in_valid  (ff_valid),
    .in_ready  (ff_ready),
    .in_item   (ff_item),
    .out_valid (fb_valid),
    .out_ready (fb_ready),
    .out_item  (fb_item)
  );

  dafb_out #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fb_valid),
    .in_ready  (fb_ready),
    .in_item   (fb_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (res)
  );

  assign m_axis_tdata = {6'b0, res.quality_out, res.sum_y, res.sum_x, res.rate_y,
                         res.rate_x, res.flow_y, res.flow_x, res.flow_y_fine,
                         res.flow_x_fine};

endmodule

>>> sim/tb.sv
// Self-checking bench for dual_axis_flow_biquad: drives flow samples, predicts each result
// with a local fixed-point biquad model and checks every output field.
// Depends on dafb_pkg and the RTL under rtl/core.
module tb;
  import dafb_pkg::*;

  localparam int COEF_FRAC   = 14;
  localparam int OUT_FRAC    = 8;
  localparam int LIMIT       = 100000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam coef_t COEF_MAX = 16'sh7FFF;
  localparam coef_t COEF_MIN = 16'sh8000;

  typedef struct {
    fine_t   fx_fine;
    fine_t   fy_fine;
    sample_t fx;
    sample_t fy;
    rate_t   rx;
    rate_t   ry;
    sum_t    sx;
    sum_t    sy;
    qual_t   q;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;

  dual_axis_flow_biquad u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // predictor state, index 0 is x, index 1 is y
  coef_t   coef [5];
  sample_t in_d1 [2];
  sample_t in_d2 [2];
  fine_t   out_d1 [2];
  fine_t   out_d2 [2];
  sum_t    raw_total [2];
  sample_t prev_flow [2];

  flow_result_t flow_expected_q [$];
  int fail_count = 0;
  int report_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;

  function automatic fine_t sat_fine(longint v);
    if (v > longint'(FINE_MAX)) return FINE_MAX;
    if (v < longint'(FINE_MIN)) return FINE_MIN;
    return fine_t'(v);
  endfunction

  function automatic fine_t biquad_step(int ax, sample_t x);
    longint acc;
    fine_t y;
    acc = (longint'(coef[REG_B0]) * x + longint'(coef[REG_B1]) * in_d1[ax]
           + longint'(coef[REG_B2]) * in_d2[ax]) * (longint'(1) << OUT_FRAC);
    acc = acc - longint'(coef[REG_A1]) * out_d1[ax] - longint'(coef[REG_A2]) * out_d2[ax];
    acc = acc + (longint'(1) << (COEF_FRAC - 1));
    y = sat_fine(acc >>> COEF_FRAC);
    in_d2[ax] = in_d1[ax];
    in_d1[ax] = x;
    out_d2[ax] = out_d1[ax];
    out_d1[ax] = y;
    return y;
  endfunction

  // truncate toward zero, then clamp to int8
  function automatic sample_t fine_to_count(fine_t f);
    longint v;
    longint q;
    v = f;
    q = (v >= 0) ? (v >>> OUT_FRAC) : -((-v) >>> OUT_FRAC);
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return sample_t'(q);
  endfunction

  function automatic flow_result_t predict_flow(sample_t dx, sample_t dy, qual_t q);
    flow_result_t r;
    fine_t fx;
    fine_t fy;
    fx = biquad_step(0, dx);
    fy = biquad_step(1, dy);
    raw_total[0] = raw_total[0] + sum_t'(dx);
    raw_total[1] = raw_total[1] + sum_t'(dy);
    r.fx_fine = sat_fine(-longint'(fy));
    r.fy_fine = sat_fine(-longint'(fx));
    r.fx = fine_to_count(r.fx_fine);
    r.fy = fine_to_count(r.fy_fine);
    r.rx = rate_t'(int'(r.fx) - int'(prev_flow[0]));
    r.ry = rate_t'(int'(r.fy) - int'(prev_flow[1]));
    prev_flow[0] = r.fx;
    prev_flow[1] = r.fy;
    r.sx = raw_total[0];
    r.sy = raw_total[1];
    r.q = q;
    return r;
  endfunction

  task automatic compare_field(string name, logic signed [63:0] exp, logic signed [63:0] act);
    if (exp !== act) begin
      fail_count++;
      report_count++;
      if (report_count <= MAX_REPORTS)
        $display("mismatch %s: expected %0d actual %0d", name, exp, act);
    end
  endtask

  task automatic check_result(logic [159:0] d);
    flow_result_t e;
    if (flow_expected_q.size() == 0) begin
      fail_count++;
      report_count++;
      if (report_count <= MAX_REPORTS) $display("unexpected result item %h", d);
    end else begin
      e = flow_expected_q.pop_front();
      compare_field("flow_x_fine", e.fx_fine, fine_t'(d[23:0]));
      compare_field("flow_y_fine", e.fy_fine, fine_t'(d[47:24]));
      compare_field("flow_x", e.fx, sample_t'(d[55:48]));
      compare_field("flow_y", e.fy, sample_t'(d[63:56]));
      compare_field("rate_x", e.rx, rate_t'(d[72:64]));
      compare_field("rate_y", e.ry, rate_t'(d[81:73]));
      compare_field("sum_x", e.sx, sum_t'(d[113:82]));
      compare_field("sum_y", e.sy, sum_t'(d[145:114]));
      compare_field("quality_out", {56'd0, e.q}, {56'd0, d[153:146]});
    end
  endtask

  // receiver: random stall per item, plus a long hold-off on request
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        stall = rx_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_sample(sample_t dx, sample_t dy, qual_t q);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q, dy, dx};
    do @(posedge clk); while (!s_axis_tready);
    flow_expected_q.push_back(predict_flow(dx, dy, q));
  endtask

  task automatic send_random_sample();
    sample_t dx;
    sample_t dy;
    dx = sample_t'($urandom);
    dy = sample_t'($urandom);
    // bias a share of items toward the field extremes
    if ($urandom_range(0, 7) == 0) dx = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
    if ($urandom_range(0, 7) == 0) dy = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
    send_sample(dx, dy, qual_t'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (flow_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; callers close a batch with end_writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= CFG_IDX_W'(REG_A2)) coef[idx] = coef_t'(val);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    end_writes();
  endtask

  task automatic test_default_coefs();
    send_sample(8'sd0, 8'sd0, 8'd0);
    send_sample(8'sh7F, 8'sh80, 8'hFF);
    send_sample(8'sh80, 8'sh7F, 8'h00);
    send_sample(-8'sd1, 8'sd1, 8'hAA);
    send_sample(8'sd1, -8'sd1, 8'h55);
    send_sample(8'sh7F, 8'sh7F, 8'hFF);
    wait_drained();
  endtask

  // odd coefficients leave fractions, so rounding and truncation toward zero show
  task automatic test_rounding();
    load_coefs(16'sd12345, -16'sd777, 16'sd3, -16'sd9000, 16'sd4000);
    send_sample(8'sd1, -8'sd1, 8'h01);
    send_sample(-8'sd1, 8'sd1, 8'h02);
    send_sample(8'sd3, -8'sd3, 8'h04);
    send_sample(-8'sd5, 8'sd7, 8'h08);
    send_sample(8'sh80, 8'sh7F, 8'h10);
    send_sample(8'sd0, 8'sd0, 8'h20);
    send_sample(8'sd0, 8'sd0, 8'h40);
    wait_drained();
  endtask

  // runaway feedback: both axes pin at the rails, y at the negative one
  task automatic test_saturation();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
    repeat (4) send_sample(8'sh7F, 8'sh80, 8'h80);
    repeat (4) send_sample(8'sh80, 8'sh7F, 8'h7F);
    wait_drained();
  endtask

  task automatic test_bad_index();
    load_coefs(16'sd16384, 16'sd4096, -16'sd2048, 16'sd1000, -16'sd500);
    for (int i = int'(REG_A2) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
    end_writes();
    send_sample(8'sd100, -8'sd100, 8'h33);
    send_sample(-8'sd50, 8'sd25, 8'hCC);
    send_sample(8'sd7, 8'sd9, 8'h0F);
    wait_drained();
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (40) send_random_sample();
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2) && (phase != 4);
      case (phase)
        0: load_coefs(B0_RESET, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        1: load_coefs(coef_t'($urandom_range(0, 4096)), coef_t'($urandom_range(0, 4096)),
                      coef_t'($urandom_range(0, 4096)),
                      coef_t'(-int'($urandom_range(16384, 26000))),
                      coef_t'($urandom_range(4096, 9000)));
        2: load_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                      coef_t'($urandom), coef_t'($urandom));
        3: load_coefs($urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                      $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                      $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                      $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                      $urandom_range(0, 1) ? COEF_MAX : COEF_MIN);
        4: load_coefs(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        default: load_coefs(coef_t'($urandom), coef_t'($urandom_range(0, 8192)),
                            coef_t'($urandom), coef_t'(-int'($urandom_range(0, 16384))),
                            coef_t'($urandom_range(0, 8192)));
      endcase
      repeat (315) send_random_sample();
      wait_drained();
    end
  endtask

  initial begin
    coef[REG_B0] = B0_RESET;
    coef[REG_B1] = '0;
    coef[REG_B2] = '0;
    coef[REG_A1] = '0;
    coef[REG_A2] = '0;
    for (int ax = 0; ax < 2; ax++) begin
      in_d1[ax] = '0;
      in_d2[ax] = '0;
      out_d1[ax] = '0;
      out_d2[ax] = '0;
      raw_total[ax] = '0;
      prev_flow[ax] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_coefs();
    test_rounding();
    test_saturation();
    test_bad_index();
    test_output_stall();
    test_random_phases();
    if (fail_count == 0 && flow_expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
